/* rtl/qlec_pkg.sv */
`timescale 1ns / 1ps

package qlec_pkg;

    // Source scalar width and the largest Unicode scalar value.
    localparam int unsigned SCALAR_W = 21;
    localparam logic [SCALAR_W-1:0] SCALAR_MAX = 21'h10FFFF;

    // Width of the shift-accumulate value of a \u{...} escape.
    localparam int unsigned ACC_W = SCALAR_W + 4;

    // Output field widths.
    localparam int unsigned OUT_LEN_W = 16;

    // Characters of interest.
    localparam logic [SCALAR_W-1:0] CH_LF        = 21'h00000A;
    localparam logic [SCALAR_W-1:0] CH_DQUOTE    = 21'h000022;
    localparam logic [SCALAR_W-1:0] CH_SQUOTE    = 21'h000027;
    localparam logic [SCALAR_W-1:0] CH_ZERO      = 21'h000030;
    localparam logic [SCALAR_W-1:0] CH_NINE      = 21'h000039;
    localparam logic [SCALAR_W-1:0] CH_UPPER_A   = 21'h000041;
    localparam logic [SCALAR_W-1:0] CH_UPPER_F   = 21'h000046;
    localparam logic [SCALAR_W-1:0] CH_BACKSLASH = 21'h00005C;
    localparam logic [SCALAR_W-1:0] CH_LOWER_A   = 21'h000061;
    localparam logic [SCALAR_W-1:0] CH_LOWER_F   = 21'h000066;
    localparam logic [SCALAR_W-1:0] CH_LOWER_N   = 21'h00006E;
    localparam logic [SCALAR_W-1:0] CH_LOWER_R   = 21'h000072;
    localparam logic [SCALAR_W-1:0] CH_LOWER_T   = 21'h000074;
    localparam logic [SCALAR_W-1:0] CH_LOWER_U   = 21'h000075;
    localparam logic [SCALAR_W-1:0] CH_LOWER_X   = 21'h000078;
    localparam logic [SCALAR_W-1:0] CH_LBRACE    = 21'h00007B;
    localparam logic [SCALAR_W-1:0] CH_RBRACE    = 21'h00007D;

    // Surrogate range, not allowed in a \u{...} escape.
    localparam logic [SCALAR_W-1:0] SURR_LO = 21'h00D800;
    localparam logic [SCALAR_W-1:0] SURR_HI = 21'h00DFFF;

    // Result outcome codes.
    typedef enum logic [1:0] {
        OUTCOME_CLOSED       = 2'd0,
        OUTCOME_NOT_LITERAL  = 2'd1,
        OUTCOME_UNTERMINATED = 2'd2
    } outcome_t;

    // Escape decoder state.
    typedef enum logic [5:0] {
        ESC_NONE     = 6'b000001,
        ESC_START    = 6'b000010,
        ESC_X_HI     = 6'b000100,
        ESC_X_LO     = 6'b001000,
        ESC_U_BRACE  = 6'b010000,
        ESC_U_DIGITS = 6'b100000
    } esc_state_t;

    // Content scalar count, saturating at two.
    localparam logic [1:0] COUNT_ONE = 2'd1;
    localparam logic [1:0] COUNT_MANY = 2'd2;

    function automatic logic is_hex(input logic [SCALAR_W-1:0] c);
        return (c >= CH_ZERO && c <= CH_NINE) ||
               (c >= CH_LOWER_A && c <= CH_LOWER_F) ||
               (c >= CH_UPPER_A && c <= CH_UPPER_F);
    endfunction

    // Digit value; only meaningful where is_hex holds.
    function automatic logic [3:0] hex_val(input logic [SCALAR_W-1:0] c);
        logic [SCALAR_W-1:0] d;
        if (c <= CH_NINE)
        begin
            d = c - CH_ZERO;
        end
        else if (c >= CH_LOWER_A)
        begin
            d = c - CH_LOWER_A + 21'd10;
        end
        else
        begin
            d = c - CH_UPPER_A + 21'd10;
        end
        return d[3:0];
    endfunction

endpackage

/* rtl/qlec_in_if.sv */
`timescale 1ns / 1ps

interface qlec_in_if
    import qlec_pkg::*;
();
    logic                valid;
    logic                ready;
    logic [SCALAR_W-1:0] scalar;
    logic                end_of_source;

    modport source (output valid, output scalar, output end_of_source, input ready);
    modport sink   (input valid, input scalar, input end_of_source, output ready);
endinterface

/* rtl/qlec_out_if.sv */
`timescale 1ns / 1ps

interface qlec_out_if
    import qlec_pkg::*;
();
    logic                 valid;
    logic                 ready;
    logic [1:0]           outcome;
    logic                 is_char_literal;
    logic [OUT_LEN_W-1:0] length;
    logic                 length_saturated;
    logic                 bad_escape;
    logic [OUT_LEN_W-1:0] bad_escape_offset;
    logic                 char_count_invalid;

    modport source (
        output valid, output outcome, output is_char_literal, output length,
        output length_saturated, output bad_escape, output bad_escape_offset,
        output char_count_invalid, input ready
    );
    modport sink (
        input valid, input outcome, input is_char_literal, input length,
        input length_saturated, input bad_escape, input bad_escape_offset,
        input char_count_invalid, output ready
    );
endinterface

/* rtl/quoted_literal_escape_checker.sv */
`timescale 1ns / 1ps

// Quoted literal escape checker. Feed the source one scalar per beat on src,
// starting at a candidate opening quote; one result beat appears on result
// when the literal closes, when a line feed or end of source cuts it off, or
// when the first scalar is not a quote or carries end of source. The block
// takes one scalar every clock cycle unless the scanner stalls: each beat
// passes through an input register and then a single step of the literal
// and escape state machine, which loads the result register. The input
// register and the result register are separate, so a scalar is still
// taken while a result waits; the scanner stalls only when a scalar would
// produce a second waiting result. Length and offsets are counted in
// LENGTH_WIDTH bits, saturate at the top and are reported in 16 bits.
module quoted_literal_escape_checker
    import qlec_pkg::*;
#(
    parameter int unsigned LENGTH_WIDTH = 16
) (
    input  logic       clk,
    input  logic       rst_n,
    qlec_in_if.sink    src,
    qlec_out_if.source result
);

    localparam logic [LENGTH_WIDTH-1:0] LEN_MAX = {LENGTH_WIDTH{1'b1}};
    localparam logic [LENGTH_WIDTH-1:0] LEN_ONE = LENGTH_WIDTH'(1);

    // Input register.
    logic                in_valid_reg;
    logic [SCALAR_W-1:0] in_scalar_reg;
    logic                in_eos_reg;

    // Scanner state.
    logic                    in_literal_reg,      in_literal_next;
    logic                    quote_single_reg,    quote_single_next;
    logic                    bs_parity_reg,       bs_parity_next;
    esc_state_t              esc_state_reg,       esc_state_next;
    logic [SCALAR_W-1:0]     esc_value_reg,       esc_value_next;
    logic                    esc_too_big_reg,     esc_too_big_next;
    logic                    esc_has_digit_reg,   esc_has_digit_next;
    logic [LENGTH_WIDTH-1:0] esc_begin_reg,       esc_begin_next;
    logic [LENGTH_WIDTH-1:0] position_reg,        position_next;
    logic                    position_sat_reg,    position_sat_next;
    logic                    first_bad_reg,       first_bad_next;
    logic [LENGTH_WIDTH-1:0] first_bad_off_reg,   first_bad_off_next;
    logic [1:0]              content_count_reg,   content_count_next;

    // Result register.
    logic                    res_valid_reg;
    outcome_t                res_outcome_reg,     res_outcome_next;
    logic                    res_is_char_reg,     res_is_char_next;
    logic [LENGTH_WIDTH-1:0] res_length_reg,      res_length_next;
    logic                    res_len_sat_reg,     res_len_sat_next;
    logic                    res_bad_reg,         res_bad_next;
    logic [LENGTH_WIDTH-1:0] res_bad_off_reg,     res_bad_off_next;
    logic                    res_cci_reg,         res_cci_next;

    logic                produce;
    logic                step;
    logic                res_free;
    logic [SCALAR_W-1:0] c;
    logic                c_is_quote;
    logic                c_closes;
    logic [ACC_W-1:0]    acc;

    assign c          = in_scalar_reg;
    assign c_is_quote = (c == CH_DQUOTE) || (c == CH_SQUOTE);
    assign c_closes   = (c == (quote_single_reg ? CH_SQUOTE : CH_DQUOTE)) && !bs_parity_reg;
    assign acc        = {esc_value_reg, hex_val(c)};

    // A result is due on this beat if it is not an opening quote while idle,
    // or if it ends an open literal.
    always_comb
    begin
        if (!in_literal_reg)
        begin
            produce = in_eos_reg || !c_is_quote;
        end
        else
        begin
            produce = in_eos_reg || (c == CH_LF) || c_closes;
        end
    end

    assign res_free  = !res_valid_reg || result.ready;
    assign step      = in_valid_reg && (!produce || res_free);
    assign src.ready = !in_valid_reg || step;

    // One step of the literal and escape state machine.
    always_comb
    begin
        in_literal_next    = in_literal_reg;
        quote_single_next  = quote_single_reg;
        bs_parity_next     = bs_parity_reg;
        esc_state_next     = esc_state_reg;
        esc_value_next     = esc_value_reg;
        esc_too_big_next   = esc_too_big_reg;
        esc_has_digit_next = esc_has_digit_reg;
        esc_begin_next     = esc_begin_reg;
        position_next      = position_reg;
        position_sat_next  = position_sat_reg;
        first_bad_next     = first_bad_reg;
        first_bad_off_next = first_bad_off_reg;
        content_count_next = content_count_reg;

        res_outcome_next = OUTCOME_NOT_LITERAL;
        res_is_char_next = 1'b0;
        res_length_next  = '0;
        res_len_sat_next = 1'b0;
        res_bad_next     = 1'b0;
        res_bad_off_next = '0;
        res_cci_next     = 1'b0;

        if (!in_literal_reg)
        begin
            // Idle: an opening quote starts a fresh literal.
            if (!produce)
            begin
                in_literal_next    = 1'b1;
                quote_single_next  = (c == CH_SQUOTE);
                bs_parity_next     = 1'b0;
                esc_state_next     = ESC_NONE;
                esc_value_next     = '0;
                esc_too_big_next   = 1'b0;
                esc_has_digit_next = 1'b0;
                esc_begin_next     = '0;
                position_next      = LEN_ONE;
                position_sat_next  = 1'b0;
                first_bad_next     = 1'b0;
                first_bad_off_next = '0;
                content_count_next = '0;
            end
        end
        else if (in_eos_reg || (c == CH_LF))
        begin
            // Cut off by a line feed or the end of the source.
            res_outcome_next = OUTCOME_UNTERMINATED;
            res_is_char_next = quote_single_reg;
            res_length_next  = position_reg;
            res_len_sat_next = position_sat_reg;
            in_literal_next  = 1'b0;
        end
        else if (c_closes)
        begin
            // Closing quote; an escape still open here is bad.
            res_outcome_next = OUTCOME_CLOSED;
            res_is_char_next = quote_single_reg;
            if (position_reg == LEN_MAX)
            begin
                res_length_next  = position_reg;
                res_len_sat_next = 1'b1;
            end
            else
            begin
                res_length_next  = position_reg + LEN_ONE;
                res_len_sat_next = position_sat_reg;
            end
            if (first_bad_reg)
            begin
                res_bad_next     = 1'b1;
                res_bad_off_next = first_bad_off_reg;
                res_cci_next     = quote_single_reg;
            end
            else if (esc_state_reg != ESC_NONE)
            begin
                res_bad_next     = 1'b1;
                res_bad_off_next = esc_begin_reg;
                res_cci_next     = quote_single_reg;
            end
            else
            begin
                res_cci_next = quote_single_reg && (content_count_reg != COUNT_ONE);
            end
            in_literal_next = 1'b0;
        end
        else
        begin
            // Ordinary content scalar.
            bs_parity_next = (c == CH_BACKSLASH) ? !bs_parity_reg : 1'b0;

            if (!first_bad_reg)
            begin
                case (esc_state_reg)
                    ESC_START:
                    begin
                        if (c inside {CH_BACKSLASH, CH_DQUOTE, CH_SQUOTE, CH_LOWER_N,
                                      CH_LOWER_R, CH_LOWER_T, CH_ZERO})
                        begin
                            esc_state_next = ESC_NONE;
                        end
                        else if (c == CH_LOWER_X)
                        begin
                            esc_state_next = ESC_X_HI;
                        end
                        else if (c == CH_LOWER_U)
                        begin
                            esc_state_next = ESC_U_BRACE;
                        end
                        else
                        begin
                            first_bad_next     = 1'b1;
                            first_bad_off_next = esc_begin_reg;
                            esc_state_next     = ESC_NONE;
                            content_count_next = COUNT_MANY;
                        end
                    end
                    ESC_X_HI:
                    begin
                        if (is_hex(c))
                        begin
                            esc_state_next = ESC_X_LO;
                        end
                        else
                        begin
                            first_bad_next     = 1'b1;
                            first_bad_off_next = esc_begin_reg;
                            esc_state_next     = ESC_NONE;
                            content_count_next = COUNT_MANY;
                        end
                    end
                    ESC_X_LO:
                    begin
                        if (!is_hex(c))
                        begin
                            first_bad_next     = 1'b1;
                            first_bad_off_next = esc_begin_reg;
                            content_count_next = COUNT_MANY;
                        end
                        esc_state_next = ESC_NONE;
                    end
                    ESC_U_BRACE:
                    begin
                        if (c == CH_LBRACE)
                        begin
                            esc_state_next     = ESC_U_DIGITS;
                            esc_value_next     = '0;
                            esc_too_big_next   = 1'b0;
                            esc_has_digit_next = 1'b0;
                        end
                        else
                        begin
                            first_bad_next     = 1'b1;
                            first_bad_off_next = esc_begin_reg;
                            esc_state_next     = ESC_NONE;
                            content_count_next = COUNT_MANY;
                        end
                    end
                    ESC_U_DIGITS:
                    begin
                        if (is_hex(c))
                        begin
                            // Accumulate; once past the scalar range, stay flagged.
                            esc_has_digit_next = 1'b1;
                            if (esc_too_big_reg || (acc > ACC_W'(SCALAR_MAX)))
                            begin
                                esc_too_big_next = 1'b1;
                            end
                            else
                            begin
                                esc_value_next = acc[SCALAR_W-1:0];
                            end
                        end
                        else if ((c == CH_RBRACE) && esc_has_digit_reg && !esc_too_big_reg &&
                                 !((esc_value_reg >= SURR_LO) && (esc_value_reg <= SURR_HI)))
                        begin
                            esc_state_next = ESC_NONE;
                        end
                        else
                        begin
                            first_bad_next     = 1'b1;
                            first_bad_off_next = esc_begin_reg;
                            esc_state_next     = ESC_NONE;
                            content_count_next = COUNT_MANY;
                        end
                    end
                    default:
                    begin
                        // No escape open: a backslash starts one.
                        if (c == CH_BACKSLASH)
                        begin
                            esc_state_next = ESC_START;
                            esc_begin_next = position_reg;
                        end
                        else
                        begin
                            esc_state_next = ESC_NONE;
                        end
                        if (content_count_reg != COUNT_MANY)
                        begin
                            content_count_next = content_count_reg + 2'd1;
                        end
                    end
                endcase
            end

            // Saturating position counter.
            if (position_reg == LEN_MAX)
            begin
                position_sat_next = 1'b1;
            end
            else
            begin
                position_next = position_reg + LEN_ONE;
            end
        end
    end

    // Input register: takes a beat whenever it is empty or being consumed.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (src.ready)
        begin
            in_valid_reg <= src.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (src.ready && src.valid)
        begin
            in_scalar_reg <= src.scalar;
            in_eos_reg    <= src.end_of_source;
        end
    end

    // Scanner state registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_literal_reg    <= 1'b0;
            quote_single_reg  <= 1'b0;
            bs_parity_reg     <= 1'b0;
            esc_state_reg     <= ESC_NONE;
            esc_value_reg     <= '0;
            esc_too_big_reg   <= 1'b0;
            esc_has_digit_reg <= 1'b0;
            esc_begin_reg     <= '0;
            position_reg      <= '0;
            position_sat_reg  <= 1'b0;
            first_bad_reg     <= 1'b0;
            first_bad_off_reg <= '0;
            content_count_reg <= '0;
        end
        else if (step)
        begin
            in_literal_reg    <= in_literal_next;
            quote_single_reg  <= quote_single_next;
            bs_parity_reg     <= bs_parity_next;
            esc_state_reg     <= esc_state_next;
            esc_value_reg     <= esc_value_next;
            esc_too_big_reg   <= esc_too_big_next;
            esc_has_digit_reg <= esc_has_digit_next;
            esc_begin_reg     <= esc_begin_next;
            position_reg      <= position_next;
            position_sat_reg  <= position_sat_next;
            first_bad_reg     <= first_bad_next;
            first_bad_off_reg <= first_bad_off_next;
            content_count_reg <= content_count_next;
        end
    end

    // Result register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            res_valid_reg <= 1'b0;
        end
        else if (step && produce)
        begin
            res_valid_reg <= 1'b1;
        end
        else if (result.ready)
        begin
            res_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (step && produce)
        begin
            res_outcome_reg <= res_outcome_next;
            res_is_char_reg <= res_is_char_next;
            res_length_reg  <= res_length_next;
            res_len_sat_reg <= res_len_sat_next;
            res_bad_reg     <= res_bad_next;
            res_bad_off_reg <= res_bad_off_next;
            res_cci_reg     <= res_cci_next;
        end
    end

    assign result.valid              = res_valid_reg;
    assign result.outcome            = res_outcome_reg;
    assign result.is_char_literal    = res_is_char_reg;
    assign result.length             = OUT_LEN_W'(res_length_reg);
    assign result.length_saturated   = res_len_sat_reg;
    assign result.bad_escape         = res_bad_reg;
    assign result.bad_escape_offset  = OUT_LEN_W'(res_bad_off_reg);
    assign result.char_count_invalid = res_cci_reg;

endmodule

/* sim/tb.sv */
`timescale 1ns / 1ps

module tb;
    import qlec_pkg::*;

    localparam int unsigned LEN_W          = 16;
    localparam logic [LEN_W-1:0] LEN_TOP   = '1;
    localparam logic [SCALAR_W-1:0] SCALAR_ALL_ONES = '1;
    localparam int unsigned PHASE_BEATS    = 140;
    localparam int unsigned MAX_REPORTS    = 10;
    localparam int unsigned DRAIN_LIMIT    = 20000;
    localparam int unsigned TAIL_CYCLES    = 10;
    localparam int unsigned N_BAD          = 13;

    // One result beat as the block reports it.
    typedef struct packed {
        outcome_t             outcome;
        logic                 is_char;
        logic [OUT_LEN_W-1:0] length;
        logic                 length_sat;
        logic                 bad_escape;
        logic [OUT_LEN_W-1:0] bad_offset;
        logic                 count_invalid;
    } verdict_t;

    // Scanner mirror: follows every accepted scalar and queues the verdicts it
    // should cause, then checks result beats against them in order.
    class literal_scoreboard;
        bit                  in_literal;
        bit                  single_quote;
        bit                  odd_backslashes;
        esc_state_t          esc;
        logic [SCALAR_W-1:0] uvalue;
        bit                  uvalue_big;
        bit                  uvalue_digit;
        logic [LEN_W-1:0]    esc_start;
        logic [LEN_W-1:0]    pos;
        bit                  pos_sat;
        bit                  bad_seen;
        logic [LEN_W-1:0]    bad_at;
        logic [1:0]          content_count;

        verdict_t            pending_verdicts[$];
        int unsigned         failures;

        function new();
            clear_literal();
            failures = 0;
        endfunction

        function void clear_literal();
            in_literal      = 1'b0;
            single_quote    = 1'b0;
            odd_backslashes = 1'b0;
            esc             = ESC_NONE;
            uvalue          = '0;
            uvalue_big      = 1'b0;
            uvalue_digit    = 1'b0;
            esc_start       = '0;
            pos             = '0;
            pos_sat         = 1'b0;
            bad_seen        = 1'b0;
            bad_at          = '0;
            content_count   = '0;
        endfunction

        // Bit 4 says the scalar is a hex digit, bits 3:0 give its value.
        function bit [4:0] digit_code(logic [SCALAR_W-1:0] c);
            if (c >= CH_ZERO && c <= CH_NINE)
                return {1'b1, 4'(c - CH_ZERO)};
            if (c >= CH_LOWER_A && c <= CH_LOWER_F)
                return {1'b1, 4'(c - CH_LOWER_A + 10)};
            if (c >= CH_UPPER_A && c <= CH_UPPER_F)
                return {1'b1, 4'(c - CH_UPPER_A + 10)};
            return 5'b0;
        endfunction

        // The first bad escape fixes the offset and spoils a char literal.
        function void flag_bad();
            bad_seen      = 1'b1;
            bad_at        = esc_start;
            esc           = ESC_NONE;
            content_count = COUNT_MANY;
        endfunction

        function void escape_step(logic [SCALAR_W-1:0] c);
            bit [4:0]            h;
            logic [SCALAR_W+3:0] acc;
            if (bad_seen)
                return;
            h = digit_code(c);
            case (esc)
                ESC_START:
                begin
                    if (c == CH_BACKSLASH || c == CH_DQUOTE || c == CH_SQUOTE ||
                        c == CH_LOWER_N || c == CH_LOWER_R || c == CH_LOWER_T ||
                        c == CH_ZERO)
                        esc = ESC_NONE;
                    else if (c == CH_LOWER_X)
                        esc = ESC_X_HI;
                    else if (c == CH_LOWER_U)
                        esc = ESC_U_BRACE;
                    else
                        flag_bad();
                end
                ESC_X_HI:
                begin
                    if (h[4])
                        esc = ESC_X_LO;
                    else
                        flag_bad();
                end
                ESC_X_LO:
                begin
                    if (h[4])
                        esc = ESC_NONE;
                    else
                        flag_bad();
                end
                ESC_U_BRACE:
                begin
                    if (c == CH_LBRACE)
                    begin
                        esc          = ESC_U_DIGITS;
                        uvalue       = '0;
                        uvalue_big   = 1'b0;
                        uvalue_digit = 1'b0;
                    end
                    else
                        flag_bad();
                end
                ESC_U_DIGITS:
                begin
                    if (h[4])
                    begin
                        acc          = {uvalue, h[3:0]};
                        uvalue_digit = 1'b1;
                        if (uvalue_big || acc > SCALAR_MAX)
                            uvalue_big = 1'b1;
                        else
                            uvalue = acc[SCALAR_W-1:0];
                    end
                    else if (c == CH_RBRACE && uvalue_digit && !uvalue_big &&
                             !(uvalue >= SURR_LO && uvalue <= SURR_HI))
                        esc = ESC_NONE;
                    else
                        flag_bad();
                end
                default:
                begin
                    if (c == CH_BACKSLASH)
                    begin
                        esc       = ESC_START;
                        esc_start = pos;
                    end
                    else
                        esc = ESC_NONE;
                    if (content_count != COUNT_MANY)
                        content_count = content_count + COUNT_ONE;
                end
            endcase
        endfunction

        // Called for every accepted input beat.
        function void take_scalar(logic [SCALAR_W-1:0] c, logic eos);
            verdict_t            v;
            bit                  produced;
            logic [SCALAR_W-1:0] closer;
            v        = '0;
            produced = 1'b0;
            closer   = single_quote ? CH_SQUOTE : CH_DQUOTE;
            if (!in_literal)
            begin
                if (!eos && (c == CH_DQUOTE || c == CH_SQUOTE))
                begin
                    clear_literal();
                    in_literal   = 1'b1;
                    single_quote = (c == CH_SQUOTE);
                    pos          = LEN_W'(1);
                end
                else
                begin
                    v.outcome = OUTCOME_NOT_LITERAL;
                    produced  = 1'b1;
                end
            end
            else if (eos || c == CH_LF)
            begin
                v.outcome    = OUTCOME_UNTERMINATED;
                v.is_char    = single_quote;
                v.length     = pos;
                v.length_sat = pos_sat;
                produced     = 1'b1;
                clear_literal();
            end
            else if (c == closer && !odd_backslashes)
            begin
                // An escape left open by the closing quote is bad.
                if (!bad_seen && esc != ESC_NONE)
                    flag_bad();
                v.outcome = OUTCOME_CLOSED;
                v.is_char = single_quote;
                if (pos == LEN_TOP)
                begin
                    v.length     = pos;
                    v.length_sat = 1'b1;
                end
                else
                begin
                    v.length     = pos + 1'b1;
                    v.length_sat = pos_sat;
                end
                v.bad_escape    = bad_seen;
                v.bad_offset    = bad_seen ? bad_at : '0;
                v.count_invalid = single_quote && content_count != COUNT_ONE;
                produced        = 1'b1;
                clear_literal();
            end
            else
            begin
                odd_backslashes = (c == CH_BACKSLASH) ? !odd_backslashes : 1'b0;
                escape_step(c);
                if (pos == LEN_TOP)
                    pos_sat = 1'b1;
                else
                    pos = pos + 1'b1;
            end
            if (produced)
                pending_verdicts = {pending_verdicts, v};
        endfunction

        function void compare_field(string name, logic [31:0] want, logic [31:0] got);
            if (got !== want)
            begin
                failures++;
                if (failures <= MAX_REPORTS)
                    $display("ERROR: %s expected %0d, got %0d", name, want, got);
            end
        endfunction

        // Called for every accepted result beat.
        function void check_verdict(verdict_t got);
            verdict_t want;
            if (pending_verdicts.size() == 0)
            begin
                failures++;
                if (failures <= MAX_REPORTS)
                    $display("ERROR: result beat with nothing expected (outcome %0d, length %0d)",
                             got.outcome, got.length);
                return;
            end
            want = pending_verdicts.pop_front();
            compare_field("outcome", want.outcome, got.outcome);
            compare_field("is_char_literal", want.is_char, got.is_char);
            compare_field("length", want.length, got.length);
            compare_field("length_saturated", want.length_sat, got.length_sat);
            compare_field("bad_escape", want.bad_escape, got.bad_escape);
            compare_field("bad_escape_offset", want.bad_offset, got.bad_offset);
            compare_field("char_count_invalid", want.count_invalid, got.count_invalid);
        endfunction
    endclass

    logic clk = 1'b0;
    logic rst_n;

    qlec_in_if  src_ch ();
    qlec_out_if res_ch ();

    quoted_literal_escape_checker #(
        .LENGTH_WIDTH (LEN_W)
    ) DUT (
        .clk    (clk),
        .rst_n  (rst_n),
        .src    (src_ch),
        .result (res_ch)
    );

    literal_scoreboard sb;
    verdict_t          result_beat;
    int unsigned       idle_pct;
    int unsigned       stall_pct;
    int unsigned       beats_sent;

    string simple_escapes = "\\\"'nrt0";
    string bad_forms [N_BAD] = '{"\\q", "\\xg", "\\x1z", "\\uA", "\\u{}", "\\u{d800}",
                                 "\\u{DFFF}", "\\u{110000}", "\\u{123456789}", "\\u{12",
                                 "\\x", "\\", "\\u{1G}"};

    // 20 ns clock.
    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    // Result side: ready changes on the falling edge, stalling at random.
    always @(negedge clk)
        res_ch.ready <= ($urandom_range(0, 99) >= stall_pct);

    // Result monitor.
    always @(posedge clk)
    begin
        if (rst_n === 1'b1 && res_ch.valid === 1'b1 && res_ch.ready === 1'b1)
        begin
            result_beat.outcome       = outcome_t'(res_ch.outcome);
            result_beat.is_char       = res_ch.is_char_literal;
            result_beat.length        = res_ch.length;
            result_beat.length_sat    = res_ch.length_saturated;
            result_beat.bad_escape    = res_ch.bad_escape;
            result_beat.bad_offset    = res_ch.bad_escape_offset;
            result_beat.count_invalid = res_ch.char_count_invalid;
            sb.check_verdict(result_beat);
        end
    end

    // Drives one input beat from a falling edge and returns on the falling
    // edge after it has been taken.
    task automatic send_beat(logic [SCALAR_W-1:0] c, logic eos);
        while ($urandom_range(0, 99) < idle_pct)
        begin
            src_ch.valid  <= 1'b0;
            src_ch.scalar <= SCALAR_W'($urandom);
            @(negedge clk);
        end
        src_ch.valid         <= 1'b1;
        src_ch.scalar        <= c;
        src_ch.end_of_source <= eos;
        @(posedge clk);
        while (src_ch.ready !== 1'b1)
            @(posedge clk);
        sb.take_scalar(c, eos);
        beats_sent++;
        @(negedge clk);
    endtask

    task automatic send_text(string s);
        for (int i = 0; i < s.len(); i++)
            send_beat(SCALAR_W'(s[i]), 1'b0);
    endtask

    function automatic string mixed_case(string s);
        return $urandom_range(0, 1) ? s.toupper() : s;
    endfunction

    // Ordinary content: mostly printable ASCII, some anywhere in the scalar
    // range and a few above it. Quotes, backslash and line feed are kept out.
    function automatic logic [SCALAR_W-1:0] content_scalar();
        logic [SCALAR_W-1:0] c;
        int unsigned         pick;
        pick = $urandom_range(0, 99);
        if (pick < 60)
            c = SCALAR_W'($urandom_range(8'h20, 8'h7E));
        else if (pick < 97)
            c = SCALAR_W'($urandom_range(0, SCALAR_MAX));
        else
            c = SCALAR_W'($urandom_range(SCALAR_MAX + 1, SCALAR_ALL_ONES));
        if (c == CH_LF || c == CH_BACKSLASH || c == CH_DQUOTE || c == CH_SQUOTE)
            c = CH_LOWER_A;
        return c;
    endfunction

    // One element of literal content: plain scalar, the other quote, escape, or broken escape.
    task automatic send_piece(bit single);
        int unsigned pick;
        int unsigned v;
        string       digits;
        pick = $urandom_range(0, 99);
        if (pick < 35)
            send_beat(content_scalar(), 1'b0);
        else if (pick < 50)
        begin
            v = $urandom_range(0, simple_escapes.len() - 1);
            send_beat(CH_BACKSLASH, 1'b0);
            send_beat(SCALAR_W'(simple_escapes[v]), 1'b0);
        end
        else if (pick < 60)
            send_text({"\\x", mixed_case($sformatf("%02h", $urandom_range(0, 255)))});
        else if (pick < 72)
        begin
            if ($urandom_range(0, 1))
                v = $urandom_range(0, SURR_LO - 1);
            else
                v = $urandom_range(SURR_HI + 1, SCALAR_MAX);
            digits = mixed_case($sformatf("%0h", v));
            repeat ($urandom_range(0, 3))
                digits = {"0", digits};
            send_text({"\\u{", digits, "}"});
        end
        else if (pick < 80)
            send_beat(single ? CH_DQUOTE : CH_SQUOTE, 1'b0);
        else
            send_text(bad_forms[$urandom_range(0, N_BAD - 1)]);
    endtask

    // A literal with random content, mostly closed properly.
    task automatic send_random_literal();
        bit                  single;
        int unsigned         pieces;
        int unsigned         ending;
        logic [SCALAR_W-1:0] q;
        single = ($urandom_range(0, 99) < 40);
        q      = single ? CH_SQUOTE : CH_DQUOTE;
        if (single)
            pieces = ($urandom_range(0, 9) < 7) ? 1 : $urandom_range(0, 3);
        else
            pieces = $urandom_range(0, 6);
        send_beat(q, 1'b0);
        repeat (pieces)
            send_piece(single);
        ending = $urandom_range(0, 99);
        if (ending < 82)
            send_beat(q, 1'b0);
        else if (ending < 88)
        begin
            send_text("\\u{1");
            send_beat(q, 1'b0);
        end
        else if (ending < 94)
            send_beat(CH_LF, 1'b0);
        else
            send_beat(SCALAR_W'($urandom), 1'b1);
    endtask

    // Beats outside a literal, all of which answer "not a literal".
    task automatic send_noise();
        case ($urandom_range(0, 3))
            0: send_beat(content_scalar(), 1'b0);
            1: send_beat(CH_LF, 1'b0);
            2: send_beat(SCALAR_W'($urandom), 1'b1);
            default: send_beat($urandom_range(0, 1) ? CH_SQUOTE : CH_DQUOTE, 1'b1);
        endcase
    endtask

    task automatic run_phase(int unsigned idle, int unsigned stall);
        int unsigned first_beat;
        idle_pct   = idle;
        stall_pct  = stall;
        first_beat = beats_sent;
        while (beats_sent - first_beat < PHASE_BEATS)
        begin
            if ($urandom_range(0, 99) < 85)
                send_random_literal();
            else
                send_noise();
        end
    endtask

    // Watchdog.
    initial
    begin
        #(64'd20_000_000);
        $display("DONE: errors detected");
        $finish;
    end

    initial
    begin
        int unsigned drain_cycles;
        sb                   = new();
        idle_pct             = 0;
        stall_pct            = 0;
        beats_sent           = 0;
        rst_n                = 1'b0;
        src_ch.valid         = 1'b0;
        src_ch.scalar        = '0;
        src_ch.end_of_source = 1'b0;
        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Directed cases, no idling.
        send_text("\"abc\"");
        send_text("'a'");
        send_text("''");
        send_text("'ab'");
        send_text("x");
        send_beat(CH_LF, 1'b0);
        send_beat(CH_DQUOTE, 1'b1);
        send_beat(SCALAR_MAX, 1'b0);
        send_beat(SCALAR_ALL_ONES, 1'b0);
        send_beat(CH_DQUOTE, 1'b0);
        send_beat(SCALAR_ALL_ONES, 1'b0);
        send_beat(SCALAR_MAX, 1'b0);
        send_beat(CH_DQUOTE, 1'b0);
        send_text("\"\\\\\\\"\\'\\n\\r\\t\\0\"");
        send_text("\"\\x41\\xfF\\x0a\"");
        send_text("\"\\u{10FFFF}\\u{0}\\u{D7FF}\\u{e000}\\u{00000000000041}\"");
        send_text("\"\\u{D800}\"");
        send_text("\"ab\\u{dfff}\"");
        send_text("\"\\u{110000}\"");
        send_text("\"\\u{}\\u41\"");
        send_text("\"a\\qb\\z\"");
        send_text("\"ab\\x\"");
        send_text("\"abc\n");
        send_text("'a");
        send_beat(CH_DQUOTE, 1'b1);
        send_text("\"a\\\\\"");
        send_text("\"a\\\"b\"");
        send_text("'\\''");
        send_text("'\"'");
        send_text("\"'\"");
        send_text("'\\q'");
        send_text("'\\n'");
        send_beat(CH_SQUOTE, 1'b0);
        send_beat(SCALAR_ALL_ONES, 1'b1);

        // Random literals under each idling pattern.
        run_phase(0, 0);
        run_phase(65, 0);
        run_phase(0, 65);
        run_phase(29, 29);
        src_ch.valid <= 1'b0;

        // Let the last results come out.
        drain_cycles = 0;
        while (sb.pending_verdicts.size() != 0 && drain_cycles < DRAIN_LIMIT)
        begin
            @(posedge clk);
            drain_cycles++;
        end
        repeat (TAIL_CYCLES) @(posedge clk);
        if (sb.pending_verdicts.size() != 0)
        begin
            $display("ERROR: %0d expected results never arrived", sb.pending_verdicts.size());
            sb.failures += sb.pending_verdicts.size();
        end
        if (sb.failures == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule

/* filelist.f */
rtl/qlec_pkg.sv
rtl/qlec_in_if.sv
rtl/qlec_out_if.sv
rtl/quoted_literal_escape_checker.sv
sim/tb.sv
